// File: hdl/sdr_pkg.sv
// Shared types and constants for the stroke dab resampler.
// No dependencies; used by sdr_fifo, sdr_front, sdr_back and the top level.
package sdr_pkg;

  localparam int POS_W   = 24;  // Q16.8 position
  localparam int DELTA_W = 25;  // position difference
  localparam int PRS_W   = 17;  // Q1.16 pressure
  localparam int SPC_W   = 16;  // Q8.8 spacing
  localparam int LEN_W   = 25;  // segment length, Q.8
  localparam int LEFT_W  = 25;  // carried leftover, Q.8
  localparam int LS_W    = 17;  // pressure-scaled spacing
  localparam int TOT_W   = 26;  // length + leftover
  localparam int SQ_W    = 50;  // dx*dx + dy*dy
  localparam int EMIT_W  = 7;   // dab count per segment, up to 64
  localparam int DIST_W  = 27;  // signed path distance of one dab
  localparam int NUM_W   = 52;  // delta * distance, signed
  localparam int QUO_W   = 51;  // rounded interpolation magnitude

  localparam logic [SPC_W-1:0] SPACING_RST = 16'd256;

  // one unit of work handed from the front end to the emitter
  typedef struct packed {
    logic                      pass;      // stroke start: emit base as is
    logic signed [POS_W-1:0]   base_x;
    logic signed [POS_W-1:0]   base_y;
    logic [PRS_W-1:0]          pressure;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [LEN_W-1:0]          len;
    logic [LS_W-1:0]           ls;
    logic [LEFT_W-1:0]         left;
    logic [EMIT_W-1:0]         emit;
    logic                      trunc;
  } cmd_t;

endpackage

// File: hdl/sdr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by sdr_front and sdr_back.
module sdr_div #(
  parameter int NW = 26,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    q_r, q_nxt;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      trial;
  logic             qbit;

  always_comb begin
    trial = {rem_r, q_r[NW-1]};
    qbit  = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
    q_nxt   = {q_r[NW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: hdl/sdr_fifo.sv
// Two-entry command queue between front end and emitter.
// Depends on sdr_pkg (cmd_t).
module sdr_fifo
  import sdr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_cmd = mem_r[rp_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

// File: hdl/sdr_front.sv
// Front end: accepts dabs, measures each segment (square root, spacing
// division), keeps stroke state and queues commands. Depends on sdr_pkg, sdr_div.
module sdr_front
  import sdr_pkg::*;
#(
  parameter int MAX_PER_SEGMENT = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SPC_W-1:0]        spacing,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_start,
  input  logic signed [POS_W-1:0] in_x,
  input  logic signed [POS_W-1:0] in_y,
  input  logic [PRS_W-1:0]        in_p,
  output logic                    push,
  output cmd_t                    cmd,
  input  logic                    full
);

  localparam logic [3:0] F_IDLE   = 4'd0;
  localparam logic [3:0] F_SQ     = 4'd1;
  localparam logic [3:0] F_INIT   = 4'd2;
  localparam logic [3:0] F_SQRT   = 4'd3;
  localparam logic [3:0] F_TOT    = 4'd4;
  localparam logic [3:0] F_DIV    = 4'd5;
  localparam logic [3:0] F_LSK    = 4'd6;
  localparam logic [3:0] F_LEFT   = 4'd7;
  localparam logic [3:0] F_PUSH   = 4'd8;
  localparam logic [3:0] F_COMMIT = 4'd9;

  logic [3:0]                state_r;
  logic                      have_r;
  logic signed [POS_W-1:0]   prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic [PRS_W-1:0]          prev_p_r, cur_p_r;
  logic [LEFT_W-1:0]         left_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic [SQ_W-2:0]           sqx_r, sqy_r;
  logic [SPC_W+PRS_W-1:0]    lsprod_r;
  logic [LS_W-1:0]           ls_r;
  logic [SQ_W-1:0]           v_r, res_r, bit_r, trial;
  logic [4:0]                it_r;
  logic [TOT_W-1:0]          tot_r, tot_c;
  logic [TOT_W-1:0]          k_r;
  logic [LS_W+TOT_W-1:0]     lsk_r;
  logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
  cmd_t                      cmd_r;
  logic                      accept, div_start, div_done;
  logic [TOT_W-1:0]          div_q;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == F_IDLE);
  assign push     = (state_r == F_PUSH) && !full;
  assign cmd      = cmd_r;
  assign trial    = res_r + bit_r;
  assign tot_c    = TOT_W'(res_r[LEN_W-1:0]) + TOT_W'(left_r);
  assign div_start = (state_r == F_TOT) && (res_r[LEN_W-1:0] != '0) && (ls_r != '0);
  // full-width signed squares
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  sdr_div #(.NW(TOT_W), .DW(LS_W)) u_kdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tot_c - 1'b1),
    .den   (ls_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      have_r   <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_p_r <= '0;
      left_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            if (in_start || !have_r) begin
              prev_x_r <= in_x;
              prev_y_r <= in_y;
              prev_p_r <= in_p;
              left_r   <= '0;
              have_r   <= 1'b1;
              state_r  <= F_PUSH;
            end else begin
              state_r <= F_SQ;
            end
          end
        end
        F_SQ:   state_r <= F_INIT;
        F_INIT: state_r <= F_SQRT;
        F_SQRT: if (it_r == 5'd24) state_r <= F_TOT;
        F_TOT: begin
          if (res_r[LEN_W-1:0] == '0) begin
            state_r <= F_COMMIT;
          end else if (ls_r == '0) begin
            left_r  <= tot_c[TOT_W-1] ? {LEFT_W{1'b1}} : tot_c[LEFT_W-1:0];
            state_r <= F_COMMIT;
          end else begin
            state_r <= F_DIV;
          end
        end
        F_DIV:  if (div_done) state_r <= F_LSK;
        F_LSK:  state_r <= F_LEFT;
        F_LEFT: begin
          // remainder after k spacings is at most ls, so it always fits
          left_r  <= LEFT_W'(tot_r - TOT_W'(lsk_r));
          state_r <= (k_r == '0) ? F_COMMIT : F_PUSH;
        end
        F_PUSH: if (!full) state_r <= F_COMMIT;
        F_COMMIT: begin
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          prev_p_r <= cur_p_r;
          state_r  <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          cur_x_r <= in_x;
          cur_y_r <= in_y;
          cur_p_r <= in_p;
          dx_r    <= DELTA_W'(in_x) - DELTA_W'(prev_x_r);
          dy_r    <= DELTA_W'(in_y) - DELTA_W'(prev_y_r);
          cmd_r.pass     <= 1'b1;
          cmd_r.base_x   <= in_x;
          cmd_r.base_y   <= in_y;
          cmd_r.pressure <= in_p;
          cmd_r.dx       <= '0;
          cmd_r.dy       <= '0;
          cmd_r.len      <= '0;
          cmd_r.ls       <= '0;
          cmd_r.left     <= '0;
          cmd_r.emit     <= EMIT_W'(1);
          cmd_r.trunc    <= 1'b0;
        end
      end
      F_SQ: begin
        sqx_r    <= sqx_full[SQ_W-2:0];
        sqy_r    <= sqy_full[SQ_W-2:0];
        lsprod_r <= spacing * prev_p_r;
      end
      F_INIT: begin
        v_r   <= SQ_W'(sqx_r) + SQ_W'(sqy_r);
        res_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
        it_r  <= '0;
        ls_r  <= lsprod_r[SPC_W+PRS_W-1:16];
      end
      F_SQRT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        it_r  <= it_r + 1'b1;
      end
      F_TOT: begin
        tot_r          <= tot_c;
        cmd_r.pass     <= 1'b0;
        cmd_r.base_x   <= prev_x_r;
        cmd_r.base_y   <= prev_y_r;
        cmd_r.pressure <= prev_p_r;
        cmd_r.dx       <= dx_r;
        cmd_r.dy       <= dy_r;
        cmd_r.len      <= res_r[LEN_W-1:0];
        cmd_r.ls       <= ls_r;
        cmd_r.left     <= left_r;
      end
      F_DIV:  if (div_done) k_r <= div_q;
      F_LSK:  lsk_r <= ls_r * k_r;
      F_LEFT: begin
        if (k_r > TOT_W'(MAX_PER_SEGMENT)) begin
          cmd_r.emit  <= EMIT_W'(MAX_PER_SEGMENT);
          cmd_r.trunc <= 1'b1;
        end else begin
          cmd_r.emit  <= k_r[EMIT_W-1:0];
          cmd_r.trunc <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/sdr_back.sv
// Emitter: walks one queued segment, interpolating each dab with two
// dividers, and drives the output register. Depends on sdr_pkg, sdr_div.
module sdr_back
  import sdr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    empty,
  input  cmd_t                    pop_cmd,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_x,
  output logic signed [POS_W-1:0] out_y,
  output logic [PRS_W-1:0]        out_p,
  output logic                    out_last,
  output logic                    out_trunc
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_PROD = 3'd1;
  localparam logic [2:0] B_D    = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_WAIT = 3'd5;
  localparam logic [2:0] B_EMIT = 3'd6;

  localparam logic signed [QUO_W+1:0] SAT_HI = (QUO_W+2)'(8388607);
  localparam logic signed [QUO_W+1:0] SAT_LO = -(QUO_W+2)'(8388608);

  logic [2:0]                state_r;
  cmd_t                      cmd_r;
  logic [EMIT_W-1:0]         n_r;
  logic [LS_W+EMIT_W-1:0]    lsn_r;
  logic signed [DIST_W-1:0]  d_r;
  logic signed [NUM_W-1:0]   numx_r, numy_r;
  logic signed [POS_W-1:0]   resx_r, resy_r;
  logic                      ovalid_r, load, last_c;
  logic [QUO_W-1:0]          divx_num, divy_num, qx, qy;
  logic                      donex, doney;

  function automatic logic [QUO_W-1:0] round_mag(input logic signed [NUM_W-1:0] v,
                                                 input logic [LEN_W-1:0] len);
    logic [NUM_W-1:0] mag;
    mag = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    return QUO_W'(mag) + QUO_W'(len >> 1);
  endfunction

  function automatic logic signed [POS_W-1:0] place(input logic signed [POS_W-1:0] base,
                                                    input logic neg,
                                                    input logic [QUO_W-1:0] q);
    logic signed [QUO_W+1:0] off, sum;
    off = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    sum = (QUO_W+2)'(base) + off;
    if (sum > SAT_HI)      return SAT_HI[POS_W-1:0];
    else if (sum < SAT_LO) return SAT_LO[POS_W-1:0];
    else                   return sum[POS_W-1:0];
  endfunction

  assign divx_num = round_mag(numx_r, cmd_r.len);
  assign divy_num = round_mag(numy_r, cmd_r.len);
  assign pop      = (state_r == B_IDLE) && !empty;
  assign load     = (state_r == B_EMIT) && (!ovalid_r || out_ready);
  assign last_c   = cmd_r.pass || (n_r == cmd_r.emit);

  sdr_div #(.NW(QUO_W), .DW(LEN_W)) u_xdiv (
    .clk(clk), .rst_n(rst_n), .start(state_r == B_DIV),
    .num(divx_num), .den(cmd_r.len), .done(donex), .quot(qx)
  );

  sdr_div #(.NW(QUO_W), .DW(LEN_W)) u_ydiv (
    .clk(clk), .rst_n(rst_n), .start(state_r == B_DIV),
    .num(divy_num), .den(cmd_r.len), .done(doney), .quot(qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (load)           ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (state_r)
        B_IDLE: if (!empty) state_r <= pop_cmd.pass ? B_EMIT : B_PROD;
        B_PROD: state_r <= B_D;
        B_D:    state_r <= B_MUL;
        B_MUL:  state_r <= B_DIV;
        B_DIV:  state_r <= B_WAIT;
        B_WAIT: if (donex && doney) state_r <= B_EMIT;
        B_EMIT: if (load) state_r <= last_c ? B_IDLE : B_PROD;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (!empty) begin
          cmd_r  <= pop_cmd;
          n_r    <= EMIT_W'(1);
          resx_r <= pop_cmd.base_x;
          resy_r <= pop_cmd.base_y;
        end
      end
      B_PROD: lsn_r <= cmd_r.ls * n_r;
      B_D:    d_r   <= $signed(DIST_W'(lsn_r)) - $signed(DIST_W'(cmd_r.left));
      B_MUL: begin
        numx_r <= cmd_r.dx * d_r;
        numy_r <= cmd_r.dy * d_r;
      end
      B_WAIT: begin
        if (donex && doney) begin
          resx_r <= place(cmd_r.base_x, numx_r[NUM_W-1], qx);
          resy_r <= place(cmd_r.base_y, numy_r[NUM_W-1], qy);
        end
      end
      B_EMIT: if (load) n_r <= n_r + 1'b1;
      default: ;
    endcase
    if (load) begin
      out_x     <= resx_r;
      out_y     <= resy_r;
      out_p     <= cmd_r.pressure;
      out_last  <= last_c;
      out_trunc <= cmd_r.trunc && !cmd_r.pass;
    end
  end

  assign out_valid = ovalid_r;

endmodule

// File: hdl/stroke_dab_resampler.sv
// Stroke dab resampler top level: spacing register, front end, queue, emitter.
// Depends on sdr_pkg, sdr_front, sdr_fifo, sdr_back, sdr_div.
//
// Usage:
//  - in_*: one pen dab per transfer; in_tuser = 1 starts a new stroke.
//    A first dab (or any dab with no stroke open) comes back out unchanged.
//  - out_*: resampled dabs; out_tlast marks the final dab caused by one
//    input dab, out_tuser flags a segment cut at MAX_PER_SEGMENT dabs.
//    An input that emits nothing (zero-length segment, zero spacing,
//    segment shorter than the remaining spacing) produces no transfer.
//  - cfg_wr_en/cfg_wr_data: spacing at full pressure, Q8.8; write only
//    while idle. Reset value 1.0 pixel.
// The front end measures each segment with a 25-step square
// root and a 26-step divider for the dab count; a zero-length segment
// or zero spacing skips the divider, and a stroke start skips both.
// The emitter places each dab with 51-step dividers for x and y, run
// side by side, after picking up the command; a passed-through dab
// skips the dividers. The two-entry queue lets the front end
// measure the next segment while dabs of the last one are still leaving.
// Reset (synchronous, active low) clears the stroke state and the queue.
// When the receiver stalls, the output register holds its dab, the
// emitter waits, then the queue fills and in_tready stays low.
module stroke_dab_resampler
  import sdr_pkg::*;
#(
  parameter int MAX_PER_SEGMENT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input dabs
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // pos_x[23:0], pos_y[47:24], pressure[64:48], zero pad
  input  logic        in_tuser,   // start_stroke
  // resampled dabs
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_x[23:0], out_y[47:24], out_pressure[64:48], zero pad
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser,  // truncated
  // spacing register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [SPC_W-1:0]        spacing_r;
  logic                    push, full, pop, empty;
  cmd_t                    push_cmd, pop_cmd;
  logic signed [POS_W-1:0] ox, oy;
  logic [PRS_W-1:0]        op;

  always_ff @(posedge clk) begin
    if (!rst_n)         spacing_r <= SPACING_RST;
    else if (cfg_wr_en) spacing_r <= cfg_wr_data;
  end

  sdr_front #(.MAX_PER_SEGMENT(MAX_PER_SEGMENT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .spacing  (spacing_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_start (in_tuser),
    .in_x     (in_tdata[23:0]),
    .in_y     (in_tdata[47:24]),
    .in_p     (in_tdata[64:48]),
    .push     (push),
    .cmd      (push_cmd),
    .full     (full)
  );

  sdr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  sdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (ox),
    .out_y     (oy),
    .out_p     (op),
    .out_last  (out_tlast),
    .out_trunc (out_tuser)
  );

  assign out_tdata = {7'd0, op, oy, ox};

endmodule

// File: tb/sv/stroke_dab_resampler_tb.sv
// Testbench for stroke_dab_resampler: drives pen dabs and spacing writes, predicts
// the resampled dabs with a behavioral model and compares every output transfer.
// Depends on sdr_pkg and the RTL under hdl/.
module stroke_dab_resampler_tb;
  import sdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;
  localparam int LIMIT_CYCLES = 20000000;
  localparam int MAX_MISMATCH_PRINT = 10;
  localparam int SETTLE_CYCLES = 400;  // front end latency for dabs that emit nothing

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [16:0]        prs;
    logic               last;
    logic               trunc;
  } dab_t;

  // directed rows: expected typed in only for pass-through dabs
  typedef struct {
    logic               start;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [16:0]        prs;
    logic               typed;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  stroke_dab_resampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0]        spacing_q = SPACING_RST;
  logic signed [23:0] last_x = '0;
  logic signed [23:0] last_y = '0;
  logic [16:0]        last_prs = '0;
  logic [24:0]        carry_dist = '0;
  logic               stroke_open = 1'b0;

  dab_t expected_dabs[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   hold_off = 1'b0;   // long receiver stall requested by stimulus
  int   hold_len = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // base + delta*d/len, rounded half away from zero, clamped to 24 bits
  function automatic logic signed [23:0] place(longint base, longint delta, longint d,
                                               longint unsigned len);
    longint num, off, v;
    longint unsigned mag, q;
    num = delta * d;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + len / 2) / len;
    off = (num < 0) ? -longint'(q) : longint'(q);
    v = base + off;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // appends one dab to the tail of the expected queue
  function automatic void add_expected(dab_t r);
    expected_dabs.insert(expected_dabs.size(), r);
  endfunction

  // updates stroke state and queues the dabs this input produces
  task automatic predict_dabs(input logic start, input logic signed [23:0] x,
                              input logic signed [23:0] y, input logic [16:0] p);
    longint dx, dy, d;
    longint unsigned len, ls, total, k, emit;
    dab_t r;
    if (start || !stroke_open) begin
      last_x = x; last_y = y; last_prs = p;
      carry_dist = '0;
      stroke_open = 1'b1;
      r = '{x: x, y: y, prs: p, last: 1'b1, trunc: 1'b0};
      add_expected(r);
      return;
    end
    dx = longint'(x) - longint'(last_x);
    dy = longint'(y) - longint'(last_y);
    len = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    ls = (longint'(spacing_q) * longint'(last_prs)) >> 16;
    total = len + carry_dist;
    if (len != 0) begin
      if (ls == 0) begin
        carry_dist = (total > 25'h1FFFFFF) ? 25'h1FFFFFF : total[24:0];
      end else begin
        k = (total == 0) ? 0 : (total - 1) / ls;
        emit = (k > CAP) ? CAP : k;
        for (longint unsigned n = 1; n <= emit; n++) begin
          d = longint'(ls * n) - longint'(carry_dist);
          r.x = place(last_x, dx, d, len);
          r.y = place(last_y, dy, d, len);
          r.prs = last_prs;
          r.last = (n == emit);
          r.trunc = (k > emit);
          add_expected(r);
        end
        total -= ls * k;
        carry_dist = (total > 25'h1FFFFFF) ? 25'h1FFFFFF : total[24:0];
      end
    end
    last_x = x; last_y = y; last_prs = p;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_off = 1'b0;
      end
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // checker on each output transfer
  always @(posedge clk) begin
    dab_t got, exp_d;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{x: out_tdata[23:0], y: out_tdata[47:24], prs: out_tdata[64:48],
              last: out_tlast, trunc: out_tuser};
      if (expected_dabs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_PRINT)
          $display("unexpected dab x=%0d y=%0d p=%0d", got.x, got.y, got.prs);
      end else begin
        exp_d = expected_dabs.pop_front();
        if (got !== exp_d || out_tdata[71:65] !== '0) begin
          mismatches++;
          if (mismatches <= MAX_MISMATCH_PRINT)
            $display("dab mismatch: exp x=%0d y=%0d p=%0d l=%b t=%b, got x=%0d y=%0d p=%0d l=%b t=%b",
                     exp_d.x, exp_d.y, exp_d.prs, exp_d.last, exp_d.trunc,
                     got.x, got.y, got.prs, got.last, got.trunc);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("stroke_dab_resampler_tb: errors");
      $finish;
    end
  end

  // one input transfer, after a random gap when gaps is set
  task automatic send_dab(input logic start, input logic signed [23:0] x,
                          input logic signed [23:0] y, input logic [16:0] p,
                          input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 4) : 0;
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {7'd0, p, y, x};
    do @(posedge clk); while (!in_tready);
    predict_dabs(start, x, y, p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_dabs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_spacing(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    spacing_q = v;
  endtask

  // random dab offset, mostly short so segments emit a handful of dabs
  function automatic logic signed [23:0] near(logic signed [23:0] base);
    int span;
    longint v;
    span = ($urandom_range(0, 9) == 0) ? 8388607 : $urandom_range(0, 6000);
    v = longint'(base) + $signed($urandom_range(0, 2 * span)) - span;
    if (v > 8388607 || v < -8388608) v = $signed($urandom());
    return v[23:0];
  endfunction

  function automatic logic [16:0] rand_prs();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return $urandom_range(4096, 65536);
    endcase
  endfunction

  row_t rows[] = '{
    '{1'b0, 24'sd0, 24'sd0, 17'd65536, 1'b1},           // no stroke open: passed through
    '{1'b0, 24'sd2560, 24'sd0, 17'd65536, 1'b0},        // 10 px along x
    '{1'b0, 24'sd2560, 24'sd0, 17'd65536, 1'b0},        // zero length
    '{1'b0, 24'sd2560, -24'sd2560, 17'd0, 1'b0},        // 10 px along -y
    '{1'b0, 24'sd0, 24'sd0, 17'd65536, 1'b0},           // zero pressure start: nothing
    '{1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 17'h1FFFF, 1'b1}, // extremes
    '{1'b0, -24'sh800000, -24'sh800000, 17'd65536, 1'b0}, // huge segment: truncated
    '{1'b1, -24'sh800000, 24'sh7FFFFF, 17'd0, 1'b1},
    '{1'b1, 24'sd100, 24'sd100, 17'd32768, 1'b1},
    '{1'b0, 24'sd150, 24'sd100, 17'd32768, 1'b0},       // shorter than spacing
    '{1'b0, 24'sd900, 24'sd100, 17'd65536, 1'b0},
    '{1'b0, 24'sd900, 24'sd5000, 17'h1FFFF, 1'b0}
  };

  initial begin
    logic signed [23:0] cx, cy;
    logic [15:0] spc[] = '{16'd1, 16'd65535, 16'd256, 16'd0, 16'd64, 16'd700};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        send_dab(rows[i].start, rows[i].x, rows[i].y, rows[i].prs, 1'b1);
        if (expected_dabs[$] !== dab_t'{rows[i].x, rows[i].y, rows[i].prs, 1'b1, 1'b0}) begin
          mismatches++;
          if (mismatches <= MAX_MISMATCH_PRINT)
            $display("pass-through row %0d: exp x=%0d y=%0d p=%0d, predicted x=%0d y=%0d p=%0d",
                     i, rows[i].x, rows[i].y, rows[i].prs,
                     expected_dabs[$].x, expected_dabs[$].y, expected_dabs[$].prs);
        end
      end else begin
        send_dab(rows[i].start, rows[i].x, rows[i].y, rows[i].prs, 1'b1);
      end
    end
    drain();

    cx = 0; cy = 0;
    foreach (spc[s]) begin
      write_spacing(spc[s]);
      if (s == 2) begin
        hold_len = 3000;   // receiver stalls long; sender keeps pushing
        hold_off = 1'b1;
      end
      for (int i = 0; i < 75; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          cx = 24'($urandom()); cy = 24'($urandom());
          send_dab(1'b1, cx, cy, rand_prs(), i % 20 >= 6);
        end else begin
          // now and then the pen stays put: zero-length segment
          if ($urandom_range(0, 15) != 0) begin
            cx = near(cx); cy = near(cy);
          end
          send_dab(1'b0, cx, cy, rand_prs(), i % 20 >= 6);
        end
        if (i == 40) drain();  // sender pauses until all dabs are out
      end
      drain();
    end

    if (mismatches == 0 && expected_dabs.size() == 0) begin
      $display("stroke_dab_resampler_tb: clean");
    end else begin
      $display("stroke_dab_resampler_tb: errors");
    end
    $finish;
  end
endmodule
